[sv/cag_pkg.sv]
// Shared types and constants of the cave automaton generation step.
// No dependencies; every file of the block but cag_fifo and cag_ram imports it.
package cag_pkg;

   // Field widths fixed by the interface
   localparam int ROW_W     = 10;
   localparam int COL_W     = 6;
   localparam int LIM_W     = 4;
   localparam int ROWS_CFG_W = 11;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;

   // Register indexes (paddr[3:2])
   localparam logic [1:0] REG_DEATH = 2'd0;
   localparam logic [1:0] REG_BIRTH = 2'd1;
   localparam logic [1:0] REG_COLS  = 2'd2;
   localparam logic [1:0] REG_ROWS  = 2'd3;

   // Register reset values
   localparam logic [LIM_W-1:0]      DEATH_RST = 4'd4;
   localparam logic [LIM_W-1:0]      BIRTH_RST = 4'd4;
   localparam logic [COL_W-1:0]      COLS_RST  = 6'd60;
   localparam logic [ROWS_CFG_W-1:0] ROWS_RST  = 11'd60;

   // Limits plus clamped grid geometry
   typedef struct packed {
      logic [LIM_W-1:0]      death_limit;
      logic [LIM_W-1:0]      birth_limit;
      logic [COL_W-1:0]      cols;
      logic [ROWS_CFG_W-1:0] rows;
   } cfg_type;

   // One classified input cell
   typedef struct packed {
      logic             cell_alive;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
   } step_type;

   // One result beat
   typedef struct packed {
      logic             next_alive;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             frame_last;
   } result_type;

   typedef enum logic {
      BACK_STREAM,
      BACK_FLUSH
   } back_state_type;

endpackage

[sv/cave_automaton_generation_step.sv]
// Top level of the cave automaton generation step.
// Depends on cag_pkg, cag_csr, cag_front, cag_fifo, cag_back and cag_ram.
//
// Usage: cells of the current generation enter in raster order, one bit per
// beat, on the req channel (push/full). Results come out on the rsp channel
// (empty/pop), each beat carrying the next-generation value of one cell with
// its row, column and a flag on the final cell of the grid. Cells off the
// grid count as alive. Limits and geometry sit behind the APB-style port.
// Throughput: one cell per cycle while the back end streams and the result
// queue has room. After the last cell of a frame the back end runs cols+1
// internal flush steps, one per cycle unless the result queue is full, to
// emit the bottom row; meanwhile up to four new cells wait in the step queue.
// The result for cell k is computed in the window stage when cell k+cols+1
// reaches it from the step queue; the flush results follow the last cell.
// When the receiver stalls, the four-entry result queue fills, then the
// window stage holds, then the step queue fills and full rises.
// Reset: limits 4/4, 60x60 grid, empty queues, position at the origin. The
// line stores need no clearing: entries outside the current frame are masked.
module cave_automaton_generation_step #(
   parameter int MAX_COLS = 60,
   parameter int MAX_ROWS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   // input cells
   input  logic                          push,
   output logic                          full,
   input  logic                          req_cell_alive,
   // results
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_next_alive,
   output logic [cag_pkg::ROW_W-1:0]     rsp_cell_row,
   output logic [cag_pkg::COL_W-1:0]     rsp_cell_col,
   output logic                          rsp_frame_last,
   // configuration
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cag_pkg::CSR_AW-1:0]    paddr,
   input  logic [cag_pkg::CSR_DW-1:0]    pwdata,
   output logic [cag_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);

   import cag_pkg::*;

   localparam int STEP_W = $bits(step_type);
   localparam int RSP_W  = $bits(result_type);
   localparam int Q_DEPTH = 4;

   cfg_type    cfg;
   logic       geom_wr;
   logic       sq_push, sq_full, sq_pop, sq_empty;
   step_type   sq_in, sq_out;
   logic       rq_push, rq_full;
   result_type rq_in, rq_out;

   cag_csr #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .geom_wr (geom_wr)
   );

   cag_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .cell_alive (req_cell_alive),
      .full       (full),
      .cfg        (cfg),
      .geom_wr    (geom_wr),
      .q_full     (sq_full),
      .q_push     (sq_push),
      .q_data     (sq_in)
   );

   // step queue between front and back
   cag_fifo #(
      .WIDTH (STEP_W),
      .DEPTH (Q_DEPTH)
   ) u_step_q (
      .clock     (clock),
      .reset     (reset),
      .push      (sq_push),
      .push_data (sq_in),
      .full      (sq_full),
      .pop       (sq_pop),
      .pop_data  (sq_out),
      .empty     (sq_empty)
   );

   cag_back #(
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_empty  (sq_empty),
      .q_data   (sq_out),
      .q_pop    (sq_pop),
      .out_full (rq_full),
      .out_push (rq_push),
      .out_data (rq_in)
   );

   // result queue toward the receiver
   cag_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (Q_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_data (rq_in),
      .full      (rq_full),
      .pop       (pop),
      .pop_data  (rq_out),
      .empty     (empty)
   );

   assign rsp_next_alive = rq_out.next_alive;
   assign rsp_cell_row   = rq_out.row;
   assign rsp_cell_col   = rq_out.col;
   assign rsp_frame_last = rq_out.frame_last;

endmodule

[sv/cag_fifo.sv]
// Small generic FIFO used for the step queue and the result queue.
// No package dependency.
module cag_fifo #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // fill count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fifo count above depth");

endmodule

[sv/cag_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No package dependency; holds the two line stores of the back end.
module cag_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 60
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

[sv/cag_csr.sv]
// APB-style register file: death/birth limits and grid geometry.
// Depends on cag_pkg; exports the clamped geometry and a geometry-write pulse.
module cag_csr #(
   parameter int MAX_COLS = 60,
   parameter int MAX_ROWS = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [cag_pkg::CSR_AW-1:0]     paddr,
   input  logic [cag_pkg::CSR_DW-1:0]     pwdata,
   output logic [cag_pkg::CSR_DW-1:0]     prdata,
   output logic                           pready,
   output cag_pkg::cfg_type               cfg,
   output logic                           geom_wr
);

   import cag_pkg::*;

   logic [LIM_W-1:0]      death_ff, death_in;
   logic [LIM_W-1:0]      birth_ff, birth_in;
   logic [COL_W-1:0]      cols_ff, cols_in;
   logic [ROWS_CFG_W-1:0] rows_ff, rows_in;
   logic [1:0]            idx;
   logic                  wr;

   assign pready = 1'b1;
   assign idx    = paddr[3:2];
   assign wr     = psel && penable && pwrite;
   assign geom_wr = wr && (idx == REG_COLS || idx == REG_ROWS);

   // register writes
   always_comb begin
      death_in = death_ff;
      birth_in = birth_ff;
      cols_in  = cols_ff;
      rows_in  = rows_ff;
      if (wr) begin
         unique case (idx)
            REG_DEATH: death_in = pwdata[LIM_W-1:0];
            REG_BIRTH: birth_in = pwdata[LIM_W-1:0];
            REG_COLS:  cols_in  = pwdata[COL_W-1:0];
            REG_ROWS:  rows_in  = pwdata[ROWS_CFG_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         death_ff <= DEATH_RST;
         birth_ff <= BIRTH_RST;
         cols_ff  <= COLS_RST;
         rows_ff  <= ROWS_RST;
      end else begin
         death_ff <= death_in;
         birth_ff <= birth_in;
         cols_ff  <= cols_in;
         rows_ff  <= rows_in;
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_DEATH: prdata = CSR_DW'(death_ff);
         REG_BIRTH: prdata = CSR_DW'(birth_ff);
         REG_COLS:  prdata = CSR_DW'(cols_ff);
         REG_ROWS:  prdata = CSR_DW'(rows_ff);
      endcase
   end

   // clamp geometry into 1..MAX
   always_comb begin
      cfg.death_limit = death_ff;
      cfg.birth_limit = birth_ff;
      if (cols_ff == '0) begin
         cfg.cols = COL_W'(1);
      end else if (cols_ff > COL_W'(MAX_COLS)) begin
         cfg.cols = COL_W'(MAX_COLS);
      end else begin
         cfg.cols = cols_ff;
      end
      if (rows_ff == '0) begin
         cfg.rows = ROWS_CFG_W'(1);
      end else if (rows_ff > ROWS_CFG_W'(MAX_ROWS)) begin
         cfg.rows = ROWS_CFG_W'(MAX_ROWS);
      end else begin
         cfg.rows = rows_ff;
      end
   end

endmodule

[sv/cag_front.sv]
// Front end: accepts input beats, tags them with grid position and end of frame.
// Depends on cag_pkg; feeds the step queue.
module cag_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              cell_alive,
   output logic              full,
   input  cag_pkg::cfg_type  cfg,
   input  logic              geom_wr,
   input  logic              q_full,
   output logic              q_push,
   output cag_pkg::step_type q_data
);

   import cag_pkg::*;

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             accept;
   logic             last;
   logic             row_end;

   assign full    = q_full;
   assign accept  = push && !q_full;
   assign q_push  = accept;
   assign row_end = (col_ff == cfg.cols - 1'b1);
   assign last    = row_end && (ROWS_CFG_W'(row_ff) == cfg.rows - 1'b1);

   assign q_data.cell_alive = cell_alive;
   assign q_data.row        = row_ff;
   assign q_data.col        = col_ff;
   assign q_data.last       = last;

   // raster position of the next cell; geometry write restarts the frame
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (geom_wr) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (last) begin
            row_in = '0;
            col_in = '0;
         end else if (row_end) begin
            row_in = row_ff + 1'b1;
            col_in = '0;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // end of frame wraps the position back to the origin
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && last && !geom_wr) |=> (row_ff == '0 && col_ff == '0))
      else $error("position did not wrap after last cell");

   // position stays on the grid
   a_pos_on_grid: assert property (@(posedge clock) disable iff (reset)
      (ROWS_CFG_W'(row_ff) < cfg.rows) && (col_ff < cfg.cols))
      else $error("input position off grid");

endmodule

[sv/cag_back.sv]
// Back end: line stores, 3x3 window, boundary masking and the death/birth limit rule (4-5 at reset).
// Depends on cag_pkg and cag_ram; after the last cell it runs w+1 flush steps.
module cag_back #(
   parameter int MAX_COLS = 60
) (
   input  logic                clock,
   input  logic                reset,
   input  cag_pkg::cfg_type    cfg,
   input  logic                q_empty,
   input  cag_pkg::step_type   q_data,
   output logic                q_pop,
   input  logic                out_full,
   output logic                out_push,
   output cag_pkg::result_type out_data
);

   import cag_pkg::*;

   localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   back_state_type        state_ff, state_in;
   logic [ROWS_CFG_W-1:0] fl_row_ff, fl_row_in;
   logic [COL_W-1:0]      fl_col_ff, fl_col_in;

   // step issue (stage 0)
   logic                  s0_valid, s0_bit, s0_adv;
   logic [ROWS_CFG_W-1:0] s0_row;
   logic [COL_W-1:0]      s0_col;

   // window update (stage 1)
   logic                  s1_v_ff, s1_v_in;
   logic                  s1_bit_ff;
   logic [ROWS_CFG_W-1:0] s1_row_ff;
   logic [COL_W-1:0]      s1_col_ff;
   logic                  s1_fire;

   // line stores: bit 1 two rows up, bit 0 one row up
   logic [1:0]            ram_rd, line, wr_data;
   logic [COL_AW-1:0]     rd_addr, wr_addr;
   logic                  fwd_ff;
   logic [1:0]            fwd_data_ff;

   // window columns: bit 2 top, bit 1 middle, bit 0 bottom
   logic [2:0]            win_left_ff, win_ctr_ff, new_col;

   logic                  emit, col_zero;
   logic [ROWS_CFG_W-1:0] cell_row;
   logic [COL_W-1:0]      cell_col;
   logic                  top_off, bot_off, left_off, right_off;
   logic                  lt, lm, lb, ct, cb, rt, rm, rb;
   logic [3:0]            count;
   logic                  next_alive;

   // step source and flush sequencer
   always_comb begin
      state_in  = state_ff;
      fl_row_in = fl_row_ff;
      fl_col_in = fl_col_ff;
      s0_valid  = 1'b0;
      s0_bit    = 1'b0;
      s0_row    = fl_row_ff;
      s0_col    = fl_col_ff;
      q_pop     = 1'b0;
      unique case (state_ff)
         BACK_STREAM: begin
            s0_valid = !q_empty;
            s0_bit   = q_data.cell_alive;
            s0_row   = ROWS_CFG_W'(q_data.row);
            s0_col   = q_data.col;
            q_pop    = s0_adv;
            if (s0_adv && q_data.last) begin
               state_in  = BACK_FLUSH;
               fl_row_in = cfg.rows;
               fl_col_in = '0;
            end
         end
         BACK_FLUSH: begin
            s0_valid = 1'b1;
            if (s0_adv) begin
               // the step at row h+1, column 0 is the final one
               if (fl_row_ff != cfg.rows) begin
                  state_in = BACK_STREAM;
               end else if (fl_col_ff == cfg.cols - 1'b1) begin
                  fl_row_in = fl_row_ff + 1'b1;
                  fl_col_in = '0;
               end else begin
                  fl_col_in = fl_col_ff + 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_STREAM;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      fl_row_ff <= fl_row_in;
      fl_col_ff <= fl_col_in;
   end

   // stage handshake
   assign s1_fire = s1_v_ff && !(emit && out_full);
   assign s0_adv  = s0_valid && (!s1_v_ff || s1_fire);

   always_comb begin
      s1_v_in = s1_v_ff;
      if (s0_adv) begin
         s1_v_in = 1'b1;
      end else if (s1_fire) begin
         s1_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_adv) begin
         s1_bit_ff <= s0_bit;
         s1_row_ff <= s0_row;
         s1_col_ff <= s0_col;
      end
   end

   // line store access; forward a same-column write (one-column grid)
   assign rd_addr = s0_col[COL_AW-1:0];
   assign wr_addr = s1_col_ff[COL_AW-1:0];
   assign line    = fwd_ff ? fwd_data_ff : ram_rd;
   assign wr_data = {line[0], s1_bit_ff};

   cag_ram #(
      .WIDTH (2),
      .DEPTH (MAX_COLS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (s0_adv),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (s0_adv) begin
         fwd_ff <= s1_fire && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (s0_adv) begin
         fwd_data_ff <= wr_data;
      end
   end

   // window shift
   assign new_col = {line[1], line[0], s1_bit_ff};

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         win_left_ff <= win_ctr_ff;
         win_ctr_ff  <= new_col;
      end
   end

   // emitted cell lags the step by one row plus one cell
   always_comb begin
      col_zero  = (s1_col_ff == '0);
      emit      = (s1_row_ff >= ROWS_CFG_W'(2)) ||
                  (s1_row_ff == ROWS_CFG_W'(1) && !col_zero);
      cell_row  = col_zero ? s1_row_ff - ROWS_CFG_W'(2) : s1_row_ff - ROWS_CFG_W'(1);
      cell_col  = col_zero ? cfg.cols - 1'b1 : s1_col_ff - 1'b1;
      top_off   = (cell_row == '0);
      bot_off   = (cell_row == cfg.rows - 1'b1);
      left_off  = (cell_col == '0);
      right_off = (cell_col == cfg.cols - 1'b1);
   end

   // neighbors; off-grid counts as alive
   always_comb begin
      lt = left_off | top_off | win_left_ff[2];
      lm = left_off | win_left_ff[1];
      lb = left_off | bot_off | win_left_ff[0];
      ct = top_off | win_ctr_ff[2];
      cb = bot_off | win_ctr_ff[0];
      rt = right_off | top_off | new_col[2];
      rm = right_off | new_col[1];
      rb = right_off | bot_off | new_col[0];
      count = 4'(lt) + 4'(lm) + 4'(lb) + 4'(ct) + 4'(cb) + 4'(rt) + 4'(rm) + 4'(rb);
      if (win_ctr_ff[1]) begin
         next_alive = (count >= cfg.death_limit);
      end else begin
         next_alive = (count > cfg.birth_limit);
      end
   end

   assign out_push            = s1_fire && emit;
   assign out_data.next_alive = next_alive;
   assign out_data.row        = cell_row[ROW_W-1:0];
   assign out_data.col        = cell_col;
   assign out_data.frame_last = bot_off && right_off;

   // flush starts only after the last cell of a frame leaves the queue
   a_flush_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == BACK_FLUSH) |-> $past(q_pop && q_data.last))
      else $error("flush started without end of frame");

   // every emitted cell lies on the grid
   a_emit_on_grid: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (cell_row < cfg.rows && cell_col < cfg.cols))
      else $error("emitted cell off grid");

endmodule

[tb/tb_cave_automaton_generation_step.sv]
// Self-checking testbench for cave_automaton_generation_step: streams grids of cells,
// predicts every next-generation beat in the bench and compares field by field.
// Depends on cag_pkg and the RTL of the block only.
module tb_cave_automaton_generation_step;
   import cag_pkg::*;

   localparam int GRID_COLS      = 60;
   localparam int GRID_ROWS      = 1024;
   localparam int SETTLE_CYCLES  = GRID_COLS + 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_CELLS   = 60;
   localparam int TAIL_CELLS     = 12;
   localparam int PRINT_CAP      = 50;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  push           = 1'b0;
   logic                  full;
   logic                  req_cell_alive = 1'b0;
   logic                  empty;
   logic                  pop            = 1'b0;
   logic                  rsp_next_alive;
   logic [ROW_W-1:0]      rsp_cell_row;
   logic [COL_W-1:0]      rsp_cell_col;
   logic                  rsp_frame_last;
   logic                  psel           = 1'b0;
   logic                  penable        = 1'b0;
   logic                  pwrite         = 1'b0;
   logic [CSR_AW-1:0]     paddr          = '0;
   logic [CSR_DW-1:0]     pwdata         = '0;
   logic [CSR_DW-1:0]     prdata;
   logic                  pready;

   cave_automaton_generation_step #(
      .MAX_COLS(GRID_COLS),
      .MAX_ROWS(GRID_ROWS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_cell_alive(req_cell_alive),
      .empty(empty),
      .pop(pop),
      .rsp_next_alive(rsp_next_alive),
      .rsp_cell_row(rsp_cell_row),
      .rsp_cell_col(rsp_cell_col),
      .rsp_frame_last(rsp_frame_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   // Predictor state: limits, geometry, four most recent rows, next input position
   logic [LIM_W-1:0]      death_lim = DEATH_RST;
   logic [LIM_W-1:0]      birth_lim = BIRTH_RST;
   logic [COL_W-1:0]      cols_cfg  = COLS_RST;
   logic [ROWS_CFG_W-1:0] rows_cfg  = ROWS_RST;
   bit                    cell_rows [0:3][0:GRID_COLS-1];
   int                    row_pos   = 0;
   int                    col_pos   = 0;

   result_type next_gen_q [$];   // next-generation beats still owed by the block
   bit         cell_q [$];       // input beats waiting for the driver

   bit send_steady = 1'b0;
   bit recv_steady = 1'b0;
   int send_gap    = 0;
   int recv_gap    = 0;
   int cells_sent  = 0;
   int results_seen = 0;
   int frames_seen = 0;
   int errors      = 0;
   int quiet_cycles = 0;

   function automatic int grid_width();
      int w;
      w = cols_cfg;
      if (w == 0) w = 1;
      if (w > GRID_COLS) w = GRID_COLS;
      return w;
   endfunction

   function automatic int grid_height();
      int h;
      h = rows_cfg;
      if (h == 0) h = 1;
      if (h > GRID_ROWS) h = GRID_ROWS;
      return h;
   endfunction

   // Next value of cell idx; neighbours off the grid count as alive
   function automatic result_type next_gen_of(int idx, int w, int h);
      int         r;
      int         c;
      int         nr;
      int         nc;
      int         count;
      bit         alive;
      result_type res;
      r = idx / w;
      c = idx % w;
      count = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            nr = r + dr;
            nc = c + dc;
            if (dr != 0 || dc != 0) begin
               if (nr < 0 || nc < 0 || nr >= h || nc >= w) count++;
               else if (cell_rows[nr % 4][nc]) count++;
            end
         end
      end
      alive = cell_rows[r % 4][c];
      res.next_alive = alive ? (count >= death_lim) : (count > birth_lim);
      res.row        = r[ROW_W-1:0];
      res.col        = c[COL_W-1:0];
      res.frame_last = (idx == w * h - 1);
      return res;
   endfunction

   // Store one accepted cell and queue the beats it releases
   task automatic advance_grid(bit alive_in);
      int w;
      int h;
      int total;
      int r;
      int c;
      int k;
      int i;
      w = grid_width();
      h = grid_height();
      total = w * h;
      r = row_pos;
      c = col_pos;
      if (r >= h || c >= w) begin
         r = 0;
         c = 0;
      end
      k = r * w + c;
      cell_rows[r % 4][c] = alive_in;
      if (k >= w + 1) next_gen_q.push_back(next_gen_of(k - w - 1, w, h));
      if (k == total - 1) begin
         // last cell of the frame flushes the bottom row
         i = (total > w + 1) ? total - w - 1 : 0;
         while (i < total) begin
            next_gen_q.push_back(next_gen_of(i, w, h));
            i++;
         end
         row_pos = 0;
         col_pos = 0;
      end else if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endtask

   task automatic report_mismatch(string msg);
      if (errors < PRINT_CAP) $display("MISMATCH: %s", msg);
      errors++;
   endtask

   // Input driver: one cell per beat, random gap before each unless send_steady is set
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            advance_grid(req_cell_alive);
            cells_sent++;
         end
         if (!push || !full) begin
            if (send_gap > 0) begin
               send_gap--;
               push <= 1'b0;
            end else if (cell_q.size() > 0) begin
               req_cell_alive <= cell_q.pop_front();
               push <= 1'b1;
               send_gap = send_steady ? 0 : $urandom_range(0, 10);
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each popped beat against the oldest prediction
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            results_seen++;
            if (rsp_frame_last === 1'b1) frames_seen++;
            if (next_gen_q.size() == 0) begin
               report_mismatch($sformatf("unexpected beat row %0d col %0d",
                                         rsp_cell_row, rsp_cell_col));
            end else begin
               want = next_gen_q.pop_front();
               if (rsp_next_alive !== want.next_alive)
                  report_mismatch($sformatf("next_alive %b want %b at row %0d col %0d",
                                            rsp_next_alive, want.next_alive,
                                            want.row, want.col));
               if (rsp_cell_row !== want.row)
                  report_mismatch($sformatf("cell_row %0d want %0d", rsp_cell_row,
                                            want.row));
               if (rsp_cell_col !== want.col)
                  report_mismatch($sformatf("cell_col %0d want %0d", rsp_cell_col,
                                            want.col));
               if (rsp_frame_last !== want.frame_last)
                  report_mismatch($sformatf("frame_last %b want %b at row %0d col %0d",
                                            rsp_frame_last, want.frame_last,
                                            want.row, want.col));
            end
            recv_gap = recv_steady ? 0 : $urandom_range(0, 10);
         end
         if (recv_gap > 0) begin
            recv_gap--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Watchdog: too long without any beat or register access
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || psel) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, next_gen_q.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // APB write; unused upper data bits carry noise
   task automatic csr_write(logic [1:0] idx, int unsigned value);
      int          fw;
      int unsigned word;
      case (idx)
         REG_DEATH, REG_BIRTH: fw = LIM_W;
         REG_COLS:             fw = COL_W;
         default:              fw = ROWS_CFG_W;
      endcase
      word = (value & ((32'd1 << fw) - 1)) | ($urandom() << fw);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // register takes the value at this edge
      case (idx)
         REG_DEATH: death_lim = word[LIM_W-1:0];
         REG_BIRTH: birth_lim = word[LIM_W-1:0];
         REG_COLS: begin
            cols_cfg = word[COL_W-1:0];
            row_pos  = 0;
            col_pos  = 0;
         end
         default: begin
            rows_cfg = word[ROWS_CFG_W-1:0];
            row_pos  = 0;
            col_pos  = 0;
         end
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic queue_pattern(logic [31:0] bits, int n);
      for (int i = 0; i < n; i++) cell_q.push_back(bits[i]);
   endtask

   task automatic queue_cells(int n, int pct);
      for (int i = 0; i < n; i++) cell_q.push_back($urandom_range(0, 99) < pct);
   endtask

   // Wait until every beat is sent and every result has come back, then let
   // the pipeline run dry before any register changes; sampled on the falling
   // edge so the driver's updates of the rising edge are already visible
   task automatic settle();
      do @(negedge clock);
      while (cell_q.size() > 0 || push || next_gen_q.size() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int          start_cells;
      int          phases;
      int          total;
      int          part;
      int          pct;
      int unsigned cols;
      int unsigned rows;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: 3x2 grid, classic limits
      csr_write(REG_COLS, 3);
      csr_write(REG_ROWS, 2);
      queue_pattern(32'b110101, 6);
      settle();

      // Zero geometry acts as a single cell; death limit above 8, birth never
      csr_write(REG_COLS, 0);
      csr_write(REG_ROWS, 0);
      csr_write(REG_DEATH, 9);
      csr_write(REG_BIRTH, 15);
      queue_pattern(32'b01, 2);
      settle();

      // Grid no bigger than one row plus one cell: all beats come at the end
      csr_write(REG_COLS, 2);
      csr_write(REG_ROWS, 1);
      csr_write(REG_DEATH, 0);
      csr_write(REG_BIRTH, 7);
      queue_pattern(32'b10, 2);
      settle();

      // Limits changed partway through a 3x3 frame
      csr_write(REG_COLS, 3);
      csr_write(REG_ROWS, 3);
      csr_write(REG_DEATH, 4);
      csr_write(REG_BIRTH, 4);
      send_steady = 1'b1;
      queue_pattern(32'b11111, 5);
      settle();
      csr_write(REG_DEATH, 5);
      csr_write(REG_BIRTH, 3);
      queue_pattern(32'b0010, 4);
      settle();

      // Geometry rewritten mid-frame drops the pending beats
      send_steady = 1'b0;
      recv_steady = 1'b1;
      queue_pattern(32'b1011001, 7);
      settle();
      csr_write(REG_COLS, 3);
      recv_steady = 1'b0;

      // Random frames, mostly small, some wide, some cut short
      start_cells = cells_sent;
      phases = 0;
      while (cells_sent - start_cells < RANDOM_CELLS) begin
         case ($urandom_range(0, 9))
            7: begin
               cols = $urandom_range(56, 63);
               rows = 1;
            end
            8: begin
               cols = $urandom_range(0, 2);
               rows = $urandom_range(0, 12);
            end
            default: begin
               cols = $urandom_range(1, 7);
               rows = $urandom_range(1, 7);
            end
         endcase
         if ($urandom_range(0, 1)) begin
            csr_write(REG_DEATH, 4);
            csr_write(REG_BIRTH, $urandom_range(4, 5));
         end else begin
            csr_write(REG_DEATH, $urandom_range(0, 15));
            csr_write(REG_BIRTH, $urandom_range(0, 15));
         end
         csr_write(REG_COLS, cols);
         csr_write(REG_ROWS, rows);
         total = grid_width() * grid_height();
         pct = $urandom_range(0, 100);
         send_steady = ($urandom_range(0, 3) == 0);
         recv_steady = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0: begin
               // abandoned frame, next geometry write restarts it
               part = (total > 1) ? $urandom_range(1, total - 1) : 1;
               queue_cells(part, pct);
               settle();
            end
            1: begin
               // limits swapped partway through the frame
               part = (total > 1) ? $urandom_range(1, total - 1) : 0;
               queue_cells(part, pct);
               settle();
               csr_write(REG_DEATH, $urandom_range(0, 15));
               csr_write(REG_BIRTH, $urandom_range(0, 15));
               queue_cells(total - part, pct);
               settle();
            end
            default: begin
               queue_cells(total, pct);
               settle();
            end
         endcase
         phases++;
      end

      // Oversized row count and zero width; the top of the frame only
      send_steady = 1'b1;
      recv_steady = 1'b1;
      csr_write(REG_DEATH, 4);
      csr_write(REG_BIRTH, 4);
      csr_write(REG_COLS, 0);
      csr_write(REG_ROWS, 2047);
      queue_cells(TAIL_CELLS, 50);
      settle();

      $display("Covered %0d cells over %0d random phases plus directed grids",
               cells_sent, phases);
      $display("Checked %0d result beats closing %0d frames, %0d mismatches",
               results_seen, frames_seen, errors);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
